// ===== rtl/core/sdd_pkg.sv =====
package sdd_pkg;

   localparam int DEFAULT_MAX_BINS = 64;
   localparam int MIN_BINS         = 3;

   localparam int FREQ_W = 19;
   localparam int MAG_W  = 16;
   localparam int COH_W  = 16;
   localparam int DEV_W  = 15;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 2;

   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_DEVIATION_THR = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_COHERENCE_THR = 1'd1;

   localparam logic [DEV_W-1:0] DEVIATION_THR_RESET = 15'd768;
   localparam logic [COH_W-1:0] COHERENCE_THR_RESET = 16'd45875;

   typedef struct packed {
      logic [FREQ_W-1:0]       freq;
      logic signed [MAG_W-1:0] mag;
      logic [COH_W-1:0]        coh;
   } bin_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_START  = 5'b00010,
      ST_DIV    = 5'b00100,
      ST_SCAN   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

endpackage

// ===== rtl/core/sdd_cell.sv =====
module sdd_cell
   import sdd_pkg::*;
(
   input  logic    clock,
   input  logic    shift,
   input  bin_type bin_i,
   output bin_type bin_o
);

   bin_type bin_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         bin_ff <= bin_i;
      end
   end

   assign bin_o = bin_ff;

endmodule

// ===== rtl/core/sdd_div.sv =====
module sdd_div
   import sdd_pkg::*;
#(
   parameter int DVD_W = 22,
   parameter int DVS_W = 7
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;

   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DVD_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/spectral_deviation_detector.sv =====
// Spectral deviation detector.
// Bins enter on the req_ stream, one beat per bin, and are held in a row of
// shift cells; tlast marks the final bin of a measurement. Bins beyond
// MAX_BINS are dropped and the run is marked as overflowed.
// Loading takes one bin per cycle. After the final bin the block stops taking
// bins, passes through a start state into a bit-serial divider that forms the
// mean magnitude, then walks the cell row, and finally sends the closing beat.
// With fewer than three bins it goes straight to the closing beat.
// Each deviating bin that also meets the coherence threshold leaves as one
// rsp_ beat in load order; rsp_tlast marks the
// final beat, and a run with nothing found sends a single beat with found low.
// A stall on rsp_tready holds the walk in place; the output register keeps
// its beat until it is taken.
// The csr_ port writes the two thresholds; write them only while idle.
// Reset restores the default thresholds, empties the store and drops any
// pending beat.
module spectral_deviation_detector
   import sdd_pkg::*;
#(
   parameter int MAX_BINS = DEFAULT_MAX_BINS
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // bin_frequency, bin_magnitude, bin_coherence
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // flagged_frequency
   output logic [RSP_USER_W-1:0] rsp_tuser,   // found, overflowed
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_BINS + 1);
   localparam int IDX_W = $clog2(MAX_BINS);
   localparam int SUM_W = MAG_W + $clog2(MAX_BINS);

   state_type state_ff, state_in;

   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic                    ovf_ff, ovf_in;
   logic [IDX_W-1:0]        scan_ff, scan_in;
   logic                    neg_ff;
   logic signed [MAG_W:0]   mean_ff, mean_in;
   logic [FREQ_W-1:0]       pend_freq_ff, pend_freq_in;
   logic                    pend_ff, pend_in;
   logic [DEV_W-1:0]        dev_thr_ff;
   logic [COH_W-1:0]        coh_thr_ff;

   logic                    out_valid_ff, out_valid_in;
   logic [FREQ_W-1:0]       out_freq_ff, out_freq_in;
   logic                    out_found_ff, out_found_in;
   logic                    out_ovf_ff, out_ovf_in;
   logic                    out_last_ff, out_last_in;

   bin_type                 req_bin;
   bin_type                 chain [MAX_BINS+1];
   logic                    chain_shift;
   logic                    accept;
   logic                    room;
   logic                    out_free;
   logic                    div_start;
   logic                    div_done;
   logic [SUM_W-1:0]        div_quo;
   logic [SUM_W-1:0]        sum_abs;
   bin_type                 head;
   logic                    in_range;
   logic signed [MAG_W+1:0] dev;
   logic [MAG_W+1:0]        dev_neg;
   logic [MAG_W:0]          dev_abs;
   logic                    qualify;
   logic                    scan_step;
   logic [MAG_W:0]          quo_lo;

   assign req_bin.freq = req_tdata[FREQ_W-1:0];
   assign req_bin.mag  = req_tdata[FREQ_W+MAG_W-1:FREQ_W];
   assign req_bin.coh  = req_tdata[FREQ_W+MAG_W+COH_W-1:FREQ_W+MAG_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign room       = (count_ff < CNT_W'(MAX_BINS));
   assign out_free   = !out_valid_ff || rsp_tready;

   assign head     = chain[MAX_BINS];
   assign in_range = ({1'b0, CNT_W'(scan_ff)} + {1'b0, count_ff}) >= (CNT_W+1)'(MAX_BINS);
   assign dev      = {{2{head.mag[MAG_W-1]}}, head.mag} - {mean_ff[MAG_W], mean_ff};
   assign dev_neg  = -dev;
   assign dev_abs  = dev[MAG_W+1] ? dev_neg[MAG_W:0] : dev[MAG_W:0];
   assign qualify  = in_range && (head.coh >= coh_thr_ff)
                     && (dev_abs > {2'b00, dev_thr_ff});

   assign scan_step   = (state_ff == ST_SCAN) && out_free;
   assign chain_shift = (accept && room) || scan_step;

   assign chain[0] = req_bin;

   for (genvar i = 0; i < MAX_BINS; i++) begin : g_cell
      sdd_cell u_cell (
         .clock (clock),
         .shift (chain_shift),
         .bin_i (chain[i]),
         .bin_o (chain[i+1])
      );
   end

   assign sum_abs   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign div_start = (state_ff == ST_START);

   sdd_div #(
      .DVD_W (SUM_W),
      .DVS_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_abs),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign quo_lo = div_quo[MAG_W:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      ovf_in       = ovf_ff;
      scan_in      = scan_ff;
      mean_in      = mean_ff;
      pend_in      = pend_ff;
      pend_freq_in = pend_freq_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_freq_in  = out_freq_ff;
      out_found_in = out_found_ff;
      out_ovf_in   = out_ovf_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (room) begin
                  count_in = count_ff + 1'b1;
                  sum_in   = sum_ff + {{(SUM_W-MAG_W){req_bin.mag[MAG_W-1]}}, req_bin.mag};
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  if (count_in >= CNT_W'(MIN_BINS)) begin
                     state_in = ST_START;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_START: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               mean_in  = neg_ff ? -$signed(quo_lo) : $signed(quo_lo);
               scan_in  = '0;
               pend_in  = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_step) begin
               if (qualify) begin
                  if (pend_ff) begin
                     out_valid_in = 1'b1;
                     out_freq_in  = pend_freq_ff;
                     out_found_in = 1'b1;
                     out_ovf_in   = ovf_ff;
                     out_last_in  = 1'b0;
                  end
                  pend_in      = 1'b1;
                  pend_freq_in = head.freq;
               end
               scan_in = scan_ff + 1'b1;
               if (scan_ff == IDX_W'(MAX_BINS - 1)) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_freq_in  = pend_ff ? pend_freq_ff : '0;
               out_found_in = pend_ff;
               out_ovf_in   = ovf_ff;
               out_last_in  = 1'b1;
               pend_in      = 1'b0;
               count_in     = '0;
               sum_in       = '0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         scan_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
         scan_ff      <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      mean_ff      <= mean_in;
      pend_freq_ff <= pend_freq_in;
      out_freq_ff  <= out_freq_in;
      out_found_ff <= out_found_in;
      out_ovf_ff   <= out_ovf_in;
      out_last_ff  <= out_last_in;
      if (div_start) begin
         neg_ff <= sum_ff[SUM_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_thr_ff <= DEVIATION_THR_RESET;
         coh_thr_ff <= COHERENCE_THR_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_DEVIATION_THR: dev_thr_ff <= csr_wdata[DEV_W-1:0];
            CSR_COHERENCE_THR: coh_thr_ff <= csr_wdata[COH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-FREQ_W){1'b0}}, out_freq_ff};
   assign rsp_tuser  = {out_ovf_ff, out_found_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== rtl/core/sdd_checker.sv =====
module sdd_checker
   import sdd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  req_tlast,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser,
   input logic                  rsp_tlast,
   input logic                  csr_we,
   input logic [CSR_ADDR_W-1:0] csr_addr,
   input logic [CSR_DATA_W-1:0] csr_wdata
);

   // A beat that reports nothing found closes its run and carries no frequency.
   a_none_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && (rsp_tdata == '0))
      else $error("beat without a finding is not a closing beat");

   // The final bin ends loading until the run has been reported.
   a_final_blocks: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("bin taken right after the final bin");

   // The block takes no bins while a result beat other than the closing one is waiting.
   a_no_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && !rsp_tlast |=> !req_tready)
      else $error("bin taken in the middle of a run report");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

endmodule

bind spectral_deviation_detector sdd_checker u_sdd_checker (.*);
